[rtl/yfr_pkg.sv]
package yfr_pkg;

    // field widths
    localparam int ROW_W  = 9;
    localparam int COL_W  = 9;
    localparam int PIX_W  = 8;
    localparam int DIM_W  = 10;
    localparam int TRIG_W = 16;
    localparam int PLANE_W = 2;

    // fixed point datapath
    localparam int FRAC_W = 14;
    localparam int DIFF_W = ROW_W + 2;
    localparam int PROD_W = TRIG_W + DIFF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int QUO_W  = SUM_W - FRAC_W;
    localparam logic [SUM_W-1:0] FRAC_MASK = SUM_W'((1 << FRAC_W) - 1);

    // stream packing
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = 1;

    // configuration
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = TRIG_W;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROWS   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLS   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SINE   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_COSINE = 2'd3;

    localparam logic [DIM_W-1:0]  ROWS_RESET   = 10'd330;
    localparam logic [DIM_W-1:0]  COLS_RESET   = 10'd440;
    localparam logic [TRIG_W-1:0] SINE_RESET   = 16'd14189;
    localparam logic [TRIG_W-1:0] COSINE_RESET = 16'hE000;

    // request kinds and planes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;
    localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [DIM_W-1:0]  rows;
        logic [DIM_W-1:0]  cols;
        logic [TRIG_W-1:0] sine;
        logic [TRIG_W-1:0] cosine;
    } yfr_cfg_t;

    typedef struct packed {
        logic             in_range;
        logic [PIX_W-1:0] pixel;
    } yfr_result_t;

endpackage

[rtl/yfr_ram.sv]
module yfr_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/yfr_rot_core.sv]
module yfr_rot_core #(
    parameter int MAX_ROWS = 512,
    parameter int MAX_COLS = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  yfr_pkg::yfr_cfg_t             cfg,
    input  logic                          in_valid,
    input  logic                          in_req,
    input  logic [yfr_pkg::PLANE_W-1:0]   in_plane,
    input  logic [yfr_pkg::ROW_W-1:0]     in_row,
    input  logic [yfr_pkg::COL_W-1:0]     in_col,
    input  logic [yfr_pkg::PIX_W-1:0]     in_pixel,
    output logic                          res_valid,
    output yfr_pkg::yfr_result_t          res
);

    localparam int DIM_W  = yfr_pkg::DIM_W;
    localparam int ROW_W  = yfr_pkg::ROW_W;
    localparam int COL_W  = yfr_pkg::COL_W;
    localparam int PIX_W  = yfr_pkg::PIX_W;
    localparam int DIFF_W = yfr_pkg::DIFF_W;
    localparam int PROD_W = yfr_pkg::PROD_W;
    localparam int SUM_W  = yfr_pkg::SUM_W;
    localparam int QUO_W  = yfr_pkg::QUO_W;
    localparam int FRAC_W = yfr_pkg::FRAC_W;

    localparam int DIM_MAX  = (1 << DIM_W) - 1;
    localparam int ROWS_LIM = (MAX_ROWS > DIM_MAX) ? DIM_MAX : MAX_ROWS;
    localparam int COLS_LIM = (MAX_COLS > DIM_MAX) ? DIM_MAX : MAX_COLS;
    localparam logic [DIM_W-1:0] ROWS_CAP = DIM_W'(ROWS_LIM);
    localparam logic [DIM_W-1:0] COLS_CAP = DIM_W'(COLS_LIM);

    localparam int LRAW = $clog2(MAX_ROWS);
    localparam int LCAW = $clog2(MAX_COLS);
    localparam int CRAW = $clog2(MAX_ROWS / 2);
    localparam int CCAW = $clog2(MAX_COLS / 2);
    localparam int LAW  = LRAW + LCAW;
    localparam int CAW  = CRAW + CCAW + 1;

    // geometry of the requested plane
    logic                    is_luma;
    logic                    is_chroma;
    logic [DIM_W-1:0]        luma_rows;
    logic [DIM_W-1:0]        luma_cols;
    logic [DIM_W-1:0]        prows_next;
    logic [DIM_W-1:0]        pcols_next;
    logic [ROW_W-1:0]        crow_next;
    logic [COL_W-1:0]        ccol_next;
    logic signed [DIFF_W-1:0] dr_next;
    logic signed [DIFF_W-1:0] dc_next;
    logic                    load_ok_next;

    always_comb
    begin
        is_luma    = (in_plane == yfr_pkg::PLANE_Y);
        is_chroma  = (in_plane == yfr_pkg::PLANE_U) || (in_plane == yfr_pkg::PLANE_V);
        luma_rows  = (cfg.rows > ROWS_CAP) ? ROWS_CAP : cfg.rows;
        luma_cols  = (cfg.cols > COLS_CAP) ? COLS_CAP : cfg.cols;
        prows_next = is_chroma ? (luma_rows >> 1) : luma_rows;
        pcols_next = is_chroma ? (luma_cols >> 1) : luma_cols;
        crow_next  = prows_next[DIM_W-1:1];
        ccol_next  = pcols_next[DIM_W-1:1];
        dr_next    = $signed({2'b00, in_row}) - $signed({2'b00, crow_next});
        dc_next    = $signed({2'b00, in_col}) - $signed({2'b00, ccol_next});
        load_ok_next = (is_luma || is_chroma)
                    && ({1'b0, in_row} < prows_next)
                    && ({1'b0, in_col} < pcols_next);
    end

    // stage 1: geometry
    logic                     s1_valid_reg;
    logic                     s1_fetch_reg;
    logic                     s1_chroma_reg;
    logic                     s1_vsel_reg;
    logic                     s1_ok_reg;
    logic                     s1_load_ok_reg;
    logic [ROW_W-1:0]         s1_row_reg;
    logic [COL_W-1:0]         s1_col_reg;
    logic [PIX_W-1:0]         s1_pixel_reg;
    logic [DIM_W-1:0]         s1_prows_reg;
    logic [DIM_W-1:0]         s1_pcols_reg;
    logic [ROW_W-1:0]         s1_crow_reg;
    logic [COL_W-1:0]         s1_ccol_reg;
    logic signed [DIFF_W-1:0] s1_dr_reg;
    logic signed [DIFF_W-1:0] s1_dc_reg;

    // stage 2: products
    logic                     s2_valid_reg;
    logic                     s2_fetch_reg;
    logic                     s2_chroma_reg;
    logic                     s2_vsel_reg;
    logic                     s2_ok_reg;
    logic                     s2_load_ok_reg;
    logic [ROW_W-1:0]         s2_row_reg;
    logic [COL_W-1:0]         s2_col_reg;
    logic [PIX_W-1:0]         s2_pixel_reg;
    logic [DIM_W-1:0]         s2_prows_reg;
    logic [DIM_W-1:0]         s2_pcols_reg;
    logic [ROW_W-1:0]         s2_crow_reg;
    logic [COL_W-1:0]         s2_ccol_reg;
    logic signed [PROD_W-1:0] s2_sin_dc_reg;
    logic signed [PROD_W-1:0] s2_cos_dr_reg;
    logic signed [PROD_W-1:0] s2_cos_dc_reg;
    logic signed [PROD_W-1:0] s2_sin_dr_reg;
    logic signed [PROD_W-1:0] sin_dc_next;
    logic signed [PROD_W-1:0] cos_dr_next;
    logic signed [PROD_W-1:0] cos_dc_next;
    logic signed [PROD_W-1:0] sin_dr_next;

    // stage 3: sums
    logic                     s3_valid_reg;
    logic                     s3_fetch_reg;
    logic                     s3_chroma_reg;
    logic                     s3_vsel_reg;
    logic                     s3_ok_reg;
    logic                     s3_load_ok_reg;
    logic [ROW_W-1:0]         s3_row_reg;
    logic [COL_W-1:0]         s3_col_reg;
    logic [PIX_W-1:0]         s3_pixel_reg;
    logic [DIM_W-1:0]         s3_prows_reg;
    logic [DIM_W-1:0]         s3_pcols_reg;
    logic [SUM_W-1:0]         s3_sum_r_reg;
    logic [SUM_W-1:0]         s3_sum_c_reg;
    logic [SUM_W-1:0]         sum_r_next;
    logic [SUM_W-1:0]         sum_c_next;

    // stage 4: memory access
    logic                     acc_valid_reg;
    logic                     acc_fetch_reg;
    logic                     acc_chroma_reg;
    logic                     acc_load_ok_reg;
    logic                     acc_in_range_reg;
    logic [PIX_W-1:0]         acc_pixel_reg;
    logic [LAW-1:0]           acc_luma_addr_reg;
    logic [CAW-1:0]           acc_chroma_addr_reg;
    logic [SUM_W-1:0]         bias_r;
    logic [SUM_W-1:0]         bias_c;
    logic [QUO_W-1:0]         q_r;
    logic [QUO_W-1:0]         q_c;
    logic                     in_range_next;
    logic [LAW-1:0]           luma_addr_next;
    logic [CAW-1:0]           chroma_addr_next;

    // stage 5: read data
    logic                     rd_valid_reg;
    logic                     rd_chroma_reg;
    logic                     rd_in_range_reg;
    logic                     luma_we;
    logic                     chroma_we;
    logic [PIX_W-1:0]         luma_rdata;
    logic [PIX_W-1:0]         chroma_rdata;

    always_comb
    begin
        sin_dc_next = $signed(cfg.sine)   * s1_dc_reg;
        cos_dr_next = $signed(cfg.cosine) * s1_dr_reg;
        cos_dc_next = $signed(cfg.cosine) * s1_dc_reg;
        sin_dr_next = $signed(cfg.sine)   * s1_dr_reg;
    end

    always_comb
    begin
        sum_r_next = {{(SUM_W-PROD_W){s2_sin_dc_reg[PROD_W-1]}}, s2_sin_dc_reg}
                   + {{(SUM_W-PROD_W){s2_cos_dr_reg[PROD_W-1]}}, s2_cos_dr_reg}
                   + {{(SUM_W-ROW_W-FRAC_W){1'b0}}, s2_crow_reg, {FRAC_W{1'b0}}};
        sum_c_next = {{(SUM_W-PROD_W){s2_cos_dc_reg[PROD_W-1]}}, s2_cos_dc_reg}
                   - {{(SUM_W-PROD_W){s2_sin_dr_reg[PROD_W-1]}}, s2_sin_dr_reg}
                   + {{(SUM_W-COL_W-FRAC_W){1'b0}}, s2_ccol_reg, {FRAC_W{1'b0}}};
    end

    // truncate toward zero: bias negative sums before the shift
    always_comb
    begin
        bias_r = s3_sum_r_reg + (s3_sum_r_reg[SUM_W-1] ? yfr_pkg::FRAC_MASK : '0);
        bias_c = s3_sum_c_reg + (s3_sum_c_reg[SUM_W-1] ? yfr_pkg::FRAC_MASK : '0);
        q_r    = bias_r[SUM_W-1:FRAC_W];
        q_c    = bias_c[SUM_W-1:FRAC_W];
        in_range_next = s3_ok_reg
                     && !q_r[QUO_W-1] && (q_r[QUO_W-2:0] < (QUO_W-1)'(s3_prows_reg))
                     && !q_c[QUO_W-1] && (q_c[QUO_W-2:0] < (QUO_W-1)'(s3_pcols_reg));
        if (s3_fetch_reg)
        begin
            luma_addr_next   = {q_r[LRAW-1:0], q_c[LCAW-1:0]};
            chroma_addr_next = {s3_vsel_reg, q_r[CRAW-1:0], q_c[CCAW-1:0]};
        end
        else
        begin
            luma_addr_next   = {LRAW'(s3_row_reg), LCAW'(s3_col_reg)};
            chroma_addr_next = {s3_vsel_reg, CRAW'(s3_row_reg), CCAW'(s3_col_reg)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            acc_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            acc_valid_reg <= s3_valid_reg;
            rd_valid_reg  <= acc_valid_reg && acc_fetch_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_fetch_reg   <= (in_req == yfr_pkg::REQ_FETCH);
        s1_chroma_reg  <= is_chroma;
        s1_vsel_reg    <= (in_plane == yfr_pkg::PLANE_V);
        s1_ok_reg      <= is_luma || is_chroma;
        s1_load_ok_reg <= load_ok_next;
        s1_row_reg     <= in_row;
        s1_col_reg     <= in_col;
        s1_pixel_reg   <= in_pixel;
        s1_prows_reg   <= prows_next;
        s1_pcols_reg   <= pcols_next;
        s1_crow_reg    <= crow_next;
        s1_ccol_reg    <= ccol_next;
        s1_dr_reg      <= dr_next;
        s1_dc_reg      <= dc_next;

        s2_fetch_reg   <= s1_fetch_reg;
        s2_chroma_reg  <= s1_chroma_reg;
        s2_vsel_reg    <= s1_vsel_reg;
        s2_ok_reg      <= s1_ok_reg;
        s2_load_ok_reg <= s1_load_ok_reg;
        s2_row_reg     <= s1_row_reg;
        s2_col_reg     <= s1_col_reg;
        s2_pixel_reg   <= s1_pixel_reg;
        s2_prows_reg   <= s1_prows_reg;
        s2_pcols_reg   <= s1_pcols_reg;
        s2_crow_reg    <= s1_crow_reg;
        s2_ccol_reg    <= s1_ccol_reg;
        s2_sin_dc_reg  <= sin_dc_next;
        s2_cos_dr_reg  <= cos_dr_next;
        s2_cos_dc_reg  <= cos_dc_next;
        s2_sin_dr_reg  <= sin_dr_next;

        s3_fetch_reg   <= s2_fetch_reg;
        s3_chroma_reg  <= s2_chroma_reg;
        s3_vsel_reg    <= s2_vsel_reg;
        s3_ok_reg      <= s2_ok_reg;
        s3_load_ok_reg <= s2_load_ok_reg;
        s3_row_reg     <= s2_row_reg;
        s3_col_reg     <= s2_col_reg;
        s3_pixel_reg   <= s2_pixel_reg;
        s3_prows_reg   <= s2_prows_reg;
        s3_pcols_reg   <= s2_pcols_reg;
        s3_sum_r_reg   <= sum_r_next;
        s3_sum_c_reg   <= sum_c_next;

        acc_fetch_reg       <= s3_fetch_reg;
        acc_chroma_reg      <= s3_chroma_reg;
        acc_load_ok_reg     <= s3_load_ok_reg;
        acc_in_range_reg    <= in_range_next;
        acc_pixel_reg       <= s3_pixel_reg;
        acc_luma_addr_reg   <= luma_addr_next;
        acc_chroma_addr_reg <= chroma_addr_next;

        rd_chroma_reg   <= acc_chroma_reg;
        rd_in_range_reg <= acc_in_range_reg;
    end

    // loads and fetches meet the stores in one stage, in request order
    assign luma_we   = acc_valid_reg && !acc_fetch_reg && acc_load_ok_reg && !acc_chroma_reg;
    assign chroma_we = acc_valid_reg && !acc_fetch_reg && acc_load_ok_reg && acc_chroma_reg;

    yfr_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (1 << LAW)
    ) u_luma_ram (
        .clk   (clk),
        .we    (luma_we),
        .addr  (acc_luma_addr_reg),
        .wdata (acc_pixel_reg),
        .rdata (luma_rdata)
    );

    // u and v share one store, split by the top address bit
    yfr_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (1 << CAW)
    ) u_chroma_ram (
        .clk   (clk),
        .we    (chroma_we),
        .addr  (acc_chroma_addr_reg),
        .wdata (acc_pixel_reg),
        .rdata (chroma_rdata)
    );

    assign res_valid    = rd_valid_reg;
    assign res.in_range = rd_in_range_reg;
    assign res.pixel    = !rd_in_range_reg ? '0 : (rd_chroma_reg ? chroma_rdata : luma_rdata);

endmodule

[rtl/yfr_out_fifo.sv]
module yfr_out_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  yfr_pkg::yfr_result_t push_data,
    input  logic                 pop,
    output logic                 valid,
    output yfr_pkg::yfr_result_t data
);

    localparam int PTR_W = yfr_pkg::FIFO_PTR_W;
    localparam int CNT_W = yfr_pkg::FIFO_CNT_W;

    yfr_pkg::yfr_result_t entry_reg [yfr_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign valid  = (count_reg != '0);
    assign do_pop = pop && valid;
    assign data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + CNT_W'(push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/yuv_frame_rotator.sv]
// YUV frame store with nearest-neighbour rotation by inverse mapping. A load request
// (tuser[0] = 0) writes one byte into the Y, U or V plane at (row, col); a fetch
// request (tuser[0] = 1) maps its output coordinate back through the configured
// sine/cosine about the plane centre and returns the stored byte, or 0 with
// in_range low when the source lies outside the plane. Loads return nothing.
// One request is taken every cycle while tready is high; a fetch result passes the
// geometry, multiply, sum, store access and read data stages and waits in an
// eight-entry result queue, so tready drops only once eight fetch results are
// outstanding. Loads and fetches reach the Y store and the shared U/V store in
// request order, so a fetch always sees earlier loads. Stores are not cleared:
// fetch only pixels that have been loaded.
module yuv_frame_rotator #(
    parameter int MAX_ROWS = 512,
    parameter int MAX_COLS = 512
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [yfr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [yfr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // requests
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [yfr_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // row, col, pixel_in, zero pad
    input  logic [yfr_pkg::IN_USER_W-1:0]       s_axis_tuser,  // req_type, plane
    // results
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [yfr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // pixel_out
    output logic [yfr_pkg::OUT_USER_W-1:0]      m_axis_tuser   // in_range
);

    localparam int CNT_W = yfr_pkg::FIFO_CNT_W;
    localparam int ROW_W = yfr_pkg::ROW_W;
    localparam int COL_W = yfr_pkg::COL_W;
    localparam int PIX_W = yfr_pkg::PIX_W;
    localparam int DIM_W = yfr_pkg::DIM_W;

    yfr_pkg::yfr_cfg_t    cfg_reg;
    yfr_pkg::yfr_result_t core_res;
    yfr_pkg::yfr_result_t out_res;
    logic                 core_valid;
    logic                 in_fire;
    logic                 fetch_fire;
    logic                 out_fire;
    logic [CNT_W-1:0]     pend_reg;
    logic [CNT_W-1:0]     pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rows   <= yfr_pkg::ROWS_RESET;
            cfg_reg.cols   <= yfr_pkg::COLS_RESET;
            cfg_reg.sine   <= yfr_pkg::SINE_RESET;
            cfg_reg.cosine <= yfr_pkg::COSINE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                yfr_pkg::CFG_ROWS:   cfg_reg.rows   <= cfg_wdata[DIM_W-1:0];
                yfr_pkg::CFG_COLS:   cfg_reg.cols   <= cfg_wdata[DIM_W-1:0];
                yfr_pkg::CFG_SINE:   cfg_reg.sine   <= cfg_wdata;
                yfr_pkg::CFG_COSINE: cfg_reg.cosine <= cfg_wdata;
                default:             cfg_reg        <= cfg_reg;
            endcase
        end
    end

    // credit count: fetches in the pipeline plus results queued
    assign s_axis_tready = (pend_reg < CNT_W'(yfr_pkg::FIFO_DEPTH));
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign fetch_fire    = in_fire && (s_axis_tuser[0] == yfr_pkg::REQ_FETCH);
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        pend_next = pend_reg + CNT_W'(fetch_fire) - CNT_W'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    yfr_rot_core #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_fire),
        .in_req    (s_axis_tuser[0]),
        .in_plane  (s_axis_tuser[2:1]),
        .in_row    (s_axis_tdata[ROW_W-1:0]),
        .in_col    (s_axis_tdata[ROW_W+COL_W-1:ROW_W]),
        .in_pixel  (s_axis_tdata[ROW_W+COL_W+PIX_W-1:ROW_W+COL_W]),
        .res_valid (core_valid),
        .res       (core_res)
    );

    yfr_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (core_valid),
        .push_data (core_res),
        .pop       (m_axis_tready),
        .valid     (m_axis_tvalid),
        .data      (out_res)
    );

    assign m_axis_tdata = out_res.pixel;
    assign m_axis_tuser = out_res.in_range;

endmodule

[tb/tb_top.sv]
module tb_top;
    import yfr_pkg::*;

    localparam int MAX_ROWS    = 512;
    localparam int MAX_COLS    = 512;
    localparam int LUMA_SLOTS  = MAX_ROWS * MAX_COLS;
    localparam int CHROMA_SLOTS = (MAX_ROWS / 2) * (MAX_COLS / 2);
    localparam int STORE_SLOTS = LUMA_SLOTS + 2 * CHROMA_SLOTS;
    localparam int Q14_ONE     = 1 << FRAC_W;
    localparam int PIPE_SETTLE = 12;
    localparam logic [PLANE_W-1:0] PLANE_NONE = 2'd3;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic             req;
        logic [1:0]       plane;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
    } pixel_req_t;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             in_range;
    } fetch_result_t;

    typedef struct {
        bit src_ok;
        int sr;
        int sc;
    } src_pos_t;

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [IN_USER_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    yuv_frame_rotator #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),   // row, col, pixel_in, zero pad
        .s_axis_tuser(s_axis_tuser),   // req_type, plane
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),   // pixel_out
        .m_axis_tuser(m_axis_tuser)    // in_range
    );

    // predictor copy of the frame and the geometry registers
    logic [PIX_W-1:0]  frame_mem [0:STORE_SLOTS-1];
    bit                loaded [0:STORE_SLOTS-1];
    logic [DIM_W-1:0]  geo_rows = ROWS_RESET;
    logic [DIM_W-1:0]  geo_cols = COLS_RESET;
    logic signed [TRIG_W-1:0] rot_sine = SINE_RESET;
    logic signed [TRIG_W-1:0] rot_cosine = COSINE_RESET;

    pixel_req_t    pending_reqs [$];
    fetch_result_t results_due [$];
    pixel_req_t    on_bus;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int queued_count = 0;
    int loads_sent = 0;
    int fetches_sent = 0;
    int results_checked = 0;
    int inside_hits = 0;
    int settings_applied = 1;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    initial
    begin
        #(8 * 400000);
        $display("== FAIL ==");
        $finish;
    end

    function automatic void plane_dims(input logic [1:0] plane, output int pr, output int pc);
        int r;
        int c;
        r = (geo_rows > MAX_ROWS) ? MAX_ROWS : int'(geo_rows);
        c = (geo_cols > MAX_COLS) ? MAX_COLS : int'(geo_cols);
        if (plane == PLANE_Y)
        begin
            pr = r;
            pc = c;
        end
        else if (plane == PLANE_U || plane == PLANE_V)
        begin
            pr = r / 2;
            pc = c / 2;
        end
        else
        begin
            pr = 0;
            pc = 0;
        end
    endfunction

    function automatic int slot_index(input logic [1:0] plane, input int r, input int c);
        if (plane == PLANE_Y)
            return r * MAX_COLS + c;
        else if (plane == PLANE_U)
            return LUMA_SLOTS + r * (MAX_COLS / 2) + c;
        else
            return LUMA_SLOTS + CHROMA_SLOTS + r * (MAX_COLS / 2) + c;
    endfunction

    function automatic bit load_hits(input logic [1:0] plane, input int row, input int col);
        int pr;
        int pc;
        plane_dims(plane, pr, pc);
        return (plane != PLANE_NONE) && (row < pr) && (col < pc);
    endfunction

    // inverse map of an output coordinate back to its source pixel
    function automatic src_pos_t rotate_source(input logic [1:0] plane,
                                               input logic [ROW_W-1:0] row,
                                               input logic [COL_W-1:0] col);
        src_pos_t s;
        int pr;
        int pc;
        longint cr;
        longint cc;
        longint dr;
        longint dc;
        longint sr;
        longint sc;
        s.src_ok = 1'b0;
        s.sr = 0;
        s.sc = 0;
        plane_dims(plane, pr, pc);
        if (plane == PLANE_NONE)
            return s;
        cr = pr / 2;
        cc = pc / 2;
        dr = longint'(row) - cr;
        dc = longint'(col) - cc;
        // longint division truncates toward zero
        sr = (longint'(rot_sine) * dc + longint'(rot_cosine) * dr + cr * Q14_ONE) / Q14_ONE;
        sc = (longint'(rot_cosine) * dc - longint'(rot_sine) * dr + cc * Q14_ONE) / Q14_ONE;
        s.sr = int'(sr);
        s.sc = int'(sc);
        s.src_ok = (sr >= 0) && (sr < pr) && (sc >= 0) && (sc < pc);
        return s;
    endfunction

    task automatic predict_request(input pixel_req_t r);
        src_pos_t s;
        fetch_result_t res;
        if (r.req == REQ_LOAD)
        begin
            if (load_hits(r.plane, r.row, r.col))
                frame_mem[slot_index(r.plane, r.row, r.col)] = r.pix;
        end
        else
        begin
            s = rotate_source(r.plane, r.row, r.col);
            res.in_range = s.src_ok;
            res.pixel = s.src_ok ? frame_mem[slot_index(r.plane, s.sr, s.sc)] : '0;
            results_due.push_back(res);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_request(on_bus);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_bus = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {6'b0, on_bus.pix, on_bus.col, on_bus.row};
                    s_axis_tuser <= {on_bus.plane, on_bus.req};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        fetch_result_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (results_due.size() == 0)
                    report_mismatch("unexpected result, pixel_out", m_axis_tdata, -1);
                else
                begin
                    want = results_due.pop_front();
                    results_checked++;
                    if (want.in_range)
                        inside_hits++;
                    if (m_axis_tdata !== want.pixel)
                        report_mismatch("pixel_out", m_axis_tdata, want.pixel);
                    if (m_axis_tuser[0] !== want.in_range)
                        report_mismatch("in_range", m_axis_tuser[0], want.in_range);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_load(input logic [1:0] plane, input int row, input int col,
                              input int pix);
        pixel_req_t r;
        r.req = REQ_LOAD;
        r.plane = plane;
        r.row = ROW_W'(row);
        r.col = COL_W'(col);
        r.pix = PIX_W'(pix);
        pending_reqs.push_back(r);
        loads_sent++;
        if (load_hits(plane, row, col))
        begin
            loaded[slot_index(plane, row, col)] = 1'b1;
            queued_count++;
        end
    endtask

    // a fetch whose source is inside but never written gets that pixel loaded first
    task automatic queue_fetch(input logic [1:0] plane, input int row, input int col);
        pixel_req_t r;
        src_pos_t s;
        s = rotate_source(plane, ROW_W'(row), COL_W'(col));
        if (s.src_ok && !loaded[slot_index(plane, s.sr, s.sc)])
            queue_load(plane, s.sr, s.sc, $urandom_range(255));
        r.req = REQ_FETCH;
        r.plane = plane;
        r.row = ROW_W'(row);
        r.col = COL_W'(col);
        r.pix = PIX_W'($urandom_range(255));
        pending_reqs.push_back(r);
        fetches_sent++;
        queued_count++;
    endtask

    function automatic logic [1:0] pick_plane();
        int k;
        k = $urandom_range(99);
        if (k < 45)
            return PLANE_Y;
        else if (k < 70)
            return PLANE_U;
        else if (k < 95)
            return PLANE_V;
        else
            return PLANE_NONE;
    endfunction

    function automatic int pick_coord(input int dim);
        if (dim > 0 && $urandom_range(3) != 0)
            return $urandom_range(dim - 1);
        else
            return $urandom_range(511);
    endfunction

    task automatic queue_random(input int target);
        logic [1:0] plane;
        int pr;
        int pc;
        int goal;
        goal = queued_count + target;
        while (queued_count < goal)
        begin
            plane = pick_plane();
            plane_dims(plane, pr, pc);
            if ($urandom_range(99) < 40)
                queue_load(plane, pick_coord(pr), pick_coord(pc), $urandom_range(255));
            else
                queue_fetch(plane, pick_coord(pr), pick_coord(pc));
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_reqs.size() != 0 || s_axis_tvalid || results_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_idle(input idle_mode_t mode);
        send_idle_pct = (mode == IDLE_SENDER) ? 73 : (mode == IDLE_BOTH) ? 21 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 73 : (mode == IDLE_BOTH) ? 21 : 0;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_ROWS:   geo_rows = value[DIM_W-1:0];
            CFG_COLS:   geo_cols = value[DIM_W-1:0];
            CFG_SINE:   rot_sine = value;
            CFG_COSINE: rot_cosine = value;
            default:    ;
        endcase
    endtask

    // pause mid-phase until every result is back, then change geometry at idle
    task automatic run_phase(input int rows, input int cols, input int sine, input int cosine,
                             input idle_mode_t mode, input int target);
        wait_drained();
        repeat (PIPE_SETTLE) @(posedge clk);
        // unused upper bits of the size writes carry junk
        write_reg(CFG_ROWS, {6'($urandom_range(63)), DIM_W'(rows)});
        write_reg(CFG_COLS, {6'($urandom_range(63)), DIM_W'(cols)});
        write_reg(CFG_SINE, TRIG_W'(sine));
        write_reg(CFG_COSINE, TRIG_W'(cosine));
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_applied++;
        set_idle(mode);
        queue_random(target / 2);
        wait_drained();
        queue_random(target - target / 2);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed, reset geometry 330 x 440, chroma 165 x 220
        set_idle(IDLE_NONE);
        queue_load(PLANE_Y, 0, 0, 0);
        queue_load(PLANE_Y, 329, 439, 255);
        queue_load(PLANE_U, 0, 0, 8'hA5);
        queue_load(PLANE_U, 164, 219, 8'h5A);
        queue_load(PLANE_V, 0, 0, 8'h01);
        queue_load(PLANE_V, 164, 219, 8'hFF);
        // loads outside the plane and to the unused plane are dropped
        queue_load(PLANE_Y, 330, 0, 8'h77);
        queue_load(PLANE_Y, 0, 440, 8'h77);
        queue_load(PLANE_U, 165, 0, 8'h77);
        queue_load(PLANE_Y, 511, 511, 8'hFF);
        queue_load(PLANE_NONE, 5, 5, 8'h33);
        queue_fetch(PLANE_Y, 165, 220);
        queue_fetch(PLANE_Y, 0, 0);
        queue_fetch(PLANE_Y, 329, 439);
        queue_fetch(PLANE_Y, 511, 511);
        queue_fetch(PLANE_U, 82, 110);
        queue_fetch(PLANE_U, 0, 0);
        queue_fetch(PLANE_V, 164, 219);
        queue_fetch(PLANE_V, 511, 0);
        queue_fetch(PLANE_NONE, 511, 511);
        queue_fetch(PLANE_NONE, 0, 0);
        wait_drained();
        queue_random(200);

        run_phase(512, 512, 0, 16384, IDLE_SENDER, 220);
        run_phase(2, 2, 16384, 0, IDLE_RECEIVER, 120);
        run_phase(512, 2, -16384, 0, IDLE_BOTH, 180);
        // zero-width luma and zero-height chroma
        run_phase(1, 0, 5000, -3000, IDLE_NONE, 40);
        // sizes above the maximum saturate
        run_phase(1023, 700, 11585, 11585, IDLE_SENDER, 220);
        run_phase(37, 301, -32768, 32767, IDLE_RECEIVER, 200);
        run_phase($urandom_range(510) + 2, $urandom_range(510) + 2,
                  int'($urandom_range(32768)) - 16384, int'($urandom_range(32768)) - 16384,
                  IDLE_BOTH, 220);
        run_phase(330, 440, -14189, -8192, IDLE_NONE, 300);

        wait_drained();
        repeat (2 * PIPE_SETTLE) @(posedge clk);
        $display("sent %0d loads and %0d fetches across %0d register settings",
                 loads_sent, fetches_sent, settings_applied);
        $display("checked %0d fetch results, %0d of them from inside the plane",
                 results_checked, inside_hits);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
